// File: rtl/eida_pkg.sv
// ----------------------------------------------------------------------------
// eida_pkg
// Shared types and constants for the ID allocator with deferred release.
// ----------------------------------------------------------------------------
package eida_pkg;

    // ID space; N_IDS must equal 2**ID_W
    localparam int ID_W   = 10;
    localparam int N_IDS  = 1 << ID_W;
    localparam int CNT_W  = ID_W + 1;

    // bitmaps are kept as rows of BM_W bits: ROW_W active bits in the low half, pending high
    localparam int BIT_AW = 5;
    localparam int ROW_W  = 1 << BIT_AW;
    localparam int ROW_AW = ID_W - BIT_AW;
    localparam int N_ROWS = 1 << ROW_AW;
    localparam int BM_W   = 2 * ROW_W;

    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_KILL   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_INACTIVE = 2'd1,
        STAT_EMPTY    = 2'd2
    } t_status;

endpackage

// File: rtl/eida_ram.sv
// ----------------------------------------------------------------------------
// eida_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/entity_id_allocator_deferred_free.sv
// ----------------------------------------------------------------------------
// entity_id_allocator_deferred_free
// ID allocator: create / kill / flush pending / clear all, with a free FIFO
// and a fresh counter, bitmaps held in a row RAM walked by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                               | tuser
//  s_      | in  | [9:0] target_id, rest zero          | [1:0] opcode
//  m_      | out | [9:0] granted_id, [20:10] rel. count | [1:0] status
//
//  Create takes the FIFO head first, else the fresh counter, and skips a candidate
//  that is still active; STAT_EMPTY when no ID is left. Kill checks the target
//  row. Flush / clear-all walk every row (read, load, scan) and release marked IDs
//  one by one (single FIFO write port). No item is taken while one is in work; a new
//  item is taken while the last beat still waits on m_tready. Reset is synchronous;
//  rows read as zero until first written (per-row valid flops), FIFO not cleared.
// ----------------------------------------------------------------------------
module entity_id_allocator_deferred_free (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [eida_pkg::S_TDATA_W-1:0] s_tdata,   // [9:0] target_id
    input  logic [eida_pkg::OP_W-1:0]      s_tuser,   // [1:0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [eida_pkg::M_TDATA_W-1:0] m_tdata,   // [9:0] granted_id, [20:10] released_count
    output logic [eida_pkg::STAT_W-1:0]    m_tuser    // [1:0] status
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_C_FETCH = 11'b000_0000_0010,
        S_C_QWAIT = 11'b000_0000_0100,
        S_C_RD    = 11'b000_0000_1000,
        S_C_CHK   = 11'b000_0001_0000,
        S_K_RD    = 11'b000_0010_0000,
        S_K_CHK   = 11'b000_0100_0000,
        S_W_RD    = 11'b000_1000_0000,
        S_W_LD    = 11'b001_0000_0000,
        S_W_SCAN  = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state                        r_state, n_state;
    eida_pkg::t_op                 r_op, n_op;
    logic [eida_pkg::ID_W-1:0]     r_target, n_target;
    logic [eida_pkg::ID_W-1:0]     r_cand, n_cand;
    logic [eida_pkg::ID_W-1:0]     r_head, n_head;
    logic [eida_pkg::CNT_W-1:0]    r_count, n_count;
    logic [eida_pkg::CNT_W-1:0]    r_fresh, n_fresh;
    logic [eida_pkg::ROW_AW-1:0]   r_row, n_row;
    logic [eida_pkg::ROW_W-1:0]    r_act, n_act;
    logic [eida_pkg::ROW_W-1:0]    r_pend, n_pend;
    logic [eida_pkg::CNT_W-1:0]    r_rel, n_rel;
    eida_pkg::t_status             r_stat, n_stat;
    logic [eida_pkg::ID_W-1:0]     r_grant, n_grant;
    logic [eida_pkg::N_ROWS-1:0]   r_row_vld, n_row_vld;
    logic                          r_rd_rowv;
    logic                          r_out_vld, n_out_vld;
    logic [eida_pkg::ID_W-1:0]     r_out_grant, n_out_grant;
    eida_pkg::t_status             r_out_stat, n_out_stat;
    logic [eida_pkg::CNT_W-1:0]    r_out_rel, n_out_rel;

    // bitmap row RAM
    logic                          bm_we;
    logic [eida_pkg::ROW_AW-1:0]   bm_waddr;
    logic [eida_pkg::BM_W-1:0]     bm_wdata;
    logic [eida_pkg::ROW_AW-1:0]   bm_raddr;
    logic [eida_pkg::BM_W-1:0]     bm_rdata;
    logic [eida_pkg::BM_W-1:0]     row_q;
    logic [eida_pkg::ROW_W-1:0]    act_q;
    logic [eida_pkg::ROW_W-1:0]    pend_q;

    // free FIFO RAM
    logic                          fq_we;
    logic [eida_pkg::ID_W-1:0]     fq_waddr;
    logic [eida_pkg::ID_W-1:0]     fq_rdata;

    // walk helpers
    logic [eida_pkg::ROW_W-1:0]    sel;
    logic [eida_pkg::ROW_W-1:0]    low1;
    logic [eida_pkg::BIT_AW-1:0]   low_idx;
    logic                          out_free;

    eida_ram #(.WIDTH(eida_pkg::BM_W), .DEPTH(eida_pkg::N_ROWS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    eida_ram #(.WIDTH(eida_pkg::ID_W), .DEPTH(eida_pkg::N_IDS)) u_free_q (
        .i_clk   (i_clk),
        .i_we    (fq_we),
        .i_waddr (fq_waddr),
        .i_wdata ({r_row, low_idx}),
        .i_raddr (r_head),
        .o_rdata (fq_rdata)
    );

    function automatic logic [eida_pkg::BIT_AW-1:0] enc_onehot(
        input logic [eida_pkg::ROW_W-1:0] oh
    );
        logic [eida_pkg::BIT_AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < eida_pkg::ROW_W; i++) begin
            if (oh[i]) begin
                idx = idx | eida_pkg::BIT_AW'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        unique case (r_state)
            S_K_RD:  bm_raddr = r_target[eida_pkg::ID_W-1:eida_pkg::BIT_AW];
            S_C_RD:  bm_raddr = r_cand[eida_pkg::ID_W-1:eida_pkg::BIT_AW];
            default: bm_raddr = r_row;
        endcase
    end

    // rows never written read as all zero
    assign row_q    = r_rd_rowv ? bm_rdata : '0;
    assign act_q    = row_q[eida_pkg::ROW_W-1:0];
    assign pend_q   = row_q[eida_pkg::BM_W-1:eida_pkg::ROW_W];

    assign sel      = (r_op == eida_pkg::OP_FLUSH) ? r_pend : r_act;
    assign low1     = sel & (~sel + eida_pkg::ROW_W'(1));
    assign low_idx  = enc_onehot(low1);
    assign fq_waddr = r_head + r_count[eida_pkg::ID_W-1:0];
    assign out_free = !r_out_vld || m_tready;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_target    = r_target;
        n_cand      = r_cand;
        n_head      = r_head;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_row       = r_row;
        n_act       = r_act;
        n_pend      = r_pend;
        n_rel       = r_rel;
        n_stat      = r_stat;
        n_grant     = r_grant;
        n_row_vld   = r_row_vld;
        n_out_vld   = (r_out_vld && m_tready) ? 1'b0 : r_out_vld;
        n_out_grant = r_out_grant;
        n_out_stat  = r_out_stat;
        n_out_rel   = r_out_rel;
        bm_we       = 1'b0;
        bm_waddr    = r_row;
        bm_wdata    = '0;
        fq_we       = 1'b0;
        s_tready    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_op     = eida_pkg::t_op'(s_tuser);
                    n_target = s_tdata[eida_pkg::ID_W-1:0];
                    n_stat   = eida_pkg::STAT_OK;
                    n_grant  = '0;
                    n_rel    = '0;
                    n_row    = '0;
                    unique case (eida_pkg::t_op'(s_tuser))
                        eida_pkg::OP_CREATE: n_state = S_C_FETCH;
                        eida_pkg::OP_KILL:   n_state = S_K_RD;
                        default:             n_state = S_W_RD;
                    endcase
                end
            end

            S_C_FETCH: begin
                if (r_count != '0) begin
                    n_head  = r_head + eida_pkg::ID_W'(1);
                    n_count = r_count - eida_pkg::CNT_W'(1);
                    n_state = S_C_QWAIT;
                end else if (r_fresh < eida_pkg::CNT_W'(eida_pkg::N_IDS)) begin
                    n_cand  = r_fresh[eida_pkg::ID_W-1:0];
                    n_fresh = r_fresh + eida_pkg::CNT_W'(1);
                    n_state = S_C_RD;
                end else begin
                    n_stat  = eida_pkg::STAT_EMPTY;
                    n_state = S_DONE;
                end
            end

            S_C_QWAIT: begin
                n_cand  = fq_rdata;
                n_state = S_C_RD;
            end

            S_C_RD: n_state = S_C_CHK;

            S_C_CHK: begin
                if (act_q[r_cand[eida_pkg::BIT_AW-1:0]]) begin
                    n_state = S_C_FETCH;   // still active: discard, try next
                end else begin
                    bm_we    = 1'b1;
                    bm_waddr = r_cand[eida_pkg::ID_W-1:eida_pkg::BIT_AW];
                    bm_wdata = row_q;
                    bm_wdata[{1'b0, r_cand[eida_pkg::BIT_AW-1:0]}] = 1'b1;
                    n_row_vld[r_cand[eida_pkg::ID_W-1:eida_pkg::BIT_AW]] = 1'b1;
                    n_grant  = r_cand;
                    n_state  = S_DONE;
                end
            end

            S_K_RD: n_state = S_K_CHK;

            S_K_CHK: begin
                if (act_q[r_target[eida_pkg::BIT_AW-1:0]]) begin
                    bm_we    = 1'b1;
                    bm_waddr = r_target[eida_pkg::ID_W-1:eida_pkg::BIT_AW];
                    bm_wdata = row_q;
                    // pending half of the row is the upper ROW_W bits
                    bm_wdata[{1'b1, r_target[eida_pkg::BIT_AW-1:0]}] = 1'b1;
                    n_row_vld[r_target[eida_pkg::ID_W-1:eida_pkg::BIT_AW]] = 1'b1;
                end else begin
                    n_stat = eida_pkg::STAT_INACTIVE;
                end
                n_state = S_DONE;
            end

            S_W_RD: n_state = S_W_LD;

            S_W_LD: begin
                n_act   = act_q;
                n_pend  = pend_q;
                n_state = S_W_SCAN;
            end

            S_W_SCAN: begin
                if (sel != '0) begin
                    // release lowest marked ID of this row
                    if (!r_count[eida_pkg::CNT_W-1]) begin
                        fq_we   = 1'b1;
                        n_count = r_count + eida_pkg::CNT_W'(1);
                    end
                    n_rel = r_rel + eida_pkg::CNT_W'(1);
                    n_act = r_act & ~low1;
                    if (r_op == eida_pkg::OP_FLUSH) begin
                        n_pend = r_pend & ~low1;
                    end
                end else begin
                    bm_we    = 1'b1;
                    bm_waddr = r_row;
                    bm_wdata = (r_op == eida_pkg::OP_FLUSH) ? {r_pend, r_act} : '0;
                    n_row_vld[r_row] = 1'b1;
                    if (r_row == eida_pkg::ROW_AW'(eida_pkg::N_ROWS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_row   = r_row + eida_pkg::ROW_AW'(1);
                        n_state = S_W_RD;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_grant = r_grant;
                    n_out_stat  = r_stat;
                    n_out_rel   = r_rel;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_fresh   <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_fresh   <= n_fresh;
            r_row_vld <= n_row_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_target    <= n_target;
        r_cand      <= n_cand;
        r_row       <= n_row;
        r_act       <= n_act;
        r_pend      <= n_pend;
        r_rel       <= n_rel;
        r_stat      <= n_stat;
        r_grant     <= n_grant;
        r_rd_rowv   <= r_row_vld[bm_raddr];
        r_out_grant <= n_out_grant;
        r_out_stat  <= n_out_stat;
        r_out_rel   <= n_out_rel;
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {{(eida_pkg::M_TDATA_W - eida_pkg::ID_W - eida_pkg::CNT_W){1'b0}},
                       r_out_rel, r_out_grant};
    assign m_tuser  = r_out_stat;

endmodule

// File: rtl/eida_chk.sv
// ----------------------------------------------------------------------------
// eida_chk
// Port-level checks for the ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module eida_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [eida_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [eida_pkg::OP_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [eida_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [eida_pkg::STAT_W-1:0]    m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops right after an accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a failed create or kill grants nothing and releases nothing
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != eida_pkg::STAT_OK |->
            m_tdata[eida_pkg::ID_W-1:0] == '0 &&
            m_tdata[eida_pkg::ID_W+eida_pkg::CNT_W-1:eida_pkg::ID_W] == '0)
        else $error("failed operation carries data");

    // a release result never grants an ID and never exceeds the ID space
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[eida_pkg::ID_W+eida_pkg::CNT_W-1:eida_pkg::ID_W] != '0 |->
            m_tdata[eida_pkg::ID_W-1:0] == '0 &&
            (!m_tdata[eida_pkg::ID_W+eida_pkg::CNT_W-1] ||
             m_tdata[eida_pkg::ID_W+eida_pkg::CNT_W-2:eida_pkg::ID_W] == '0))
        else $error("bad release result");

    // no result beat right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind entity_id_allocator_deferred_free eida_chk u_eida_chk (.*);

// File: test/tb_entity_id_allocator_deferred_free.sv
// ----------------------------------------------------------------------------
// tb_entity_id_allocator_deferred_free
// Self-checking bench for the ID allocator. Request beats (create, kill,
// flush, clear-all) come from a queue filled by a generator. An in-bench
// model of the maps, free FIFO and fresh counter predicts one reply per
// accepted request. Replies are compared field by field in order. Both
// sides idle at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_entity_id_allocator_deferred_free;

    localparam int ID_W      = eida_pkg::ID_W;
    localparam int N_IDS     = eida_pkg::N_IDS;
    localparam int CNT_W     = eida_pkg::CNT_W;
    localparam int OP_W      = eida_pkg::OP_W;
    localparam int STAT_W    = eida_pkg::STAT_W;
    localparam int S_TDATA_W = eida_pkg::S_TDATA_W;
    localparam int M_TDATA_W = eida_pkg::M_TDATA_W;

    localparam int N_REQS   = 1850;
    localparam int MAX_GAP  = 17;
    localparam int DRAIN_CY = 1500;   // longest flush/clear walk plus margin

    typedef struct packed {
        eida_pkg::t_op   op;
        logic [ID_W-1:0] tgt;
    } t_alloc_req;

    typedef struct {
        logic [ID_W-1:0]   id;
        eida_pkg::t_status st;
        logic [CNT_W-1:0]  cnt;
    } t_alloc_reply;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = eida_pkg::OP_CREATE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    entity_id_allocator_deferred_free uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    // allocator model state
    bit              act_map  [N_IDS];
    bit              pend_map [N_IDS];
    logic [ID_W-1:0] free_ids [N_IDS];
    int              free_rd    = 0;
    int              free_cnt   = 0;
    int              fresh_next = 0;

    t_alloc_req   req_q[$];
    t_alloc_reply owed_replies[$];

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int tx_gap  = 0;
    int rx_gap  = 0;
    int n_queued = 0;

    int n_err     = 0;
    int n_beats   = 0;
    int n_grants  = 0;
    int n_refused = 0;
    int n_dry     = 0;
    int max_batch = 0;

    function automatic void release_id(logic [ID_W-1:0] id);
        // a push into a full FIFO is dropped, the ID still counts as released
        if (free_cnt < N_IDS) begin
            free_ids[(free_rd + free_cnt) % N_IDS] = id;
            free_cnt++;
        end
    endfunction

    function automatic void apply_op(eida_pkg::t_op op, logic [ID_W-1:0] tgt);
        t_alloc_reply    r;
        logic [ID_W-1:0] cand;
        bit              found;
        bit              more;
        r.id  = '0;
        r.st  = eida_pkg::STAT_OK;
        r.cnt = '0;
        cand  = '0;
        case (op)
            eida_pkg::OP_CREATE: begin
                found = 1'b0;
                more  = 1'b1;
                // FIFO first, then fresh counter; active candidates are dropped
                while (more && !found) begin
                    if (free_cnt > 0) begin
                        cand    = free_ids[free_rd];
                        free_rd = (free_rd + 1) % N_IDS;
                        free_cnt--;
                    end else if (fresh_next < N_IDS) begin
                        cand = ID_W'(fresh_next);
                        fresh_next++;
                    end else begin
                        more = 1'b0;
                    end
                    if (more && !act_map[cand])
                        found = 1'b1;
                end
                if (found) begin
                    act_map[cand] = 1'b1;
                    r.id = cand;
                end else begin
                    r.st = eida_pkg::STAT_EMPTY;
                end
            end
            eida_pkg::OP_KILL: begin
                if (!act_map[tgt])
                    r.st = eida_pkg::STAT_INACTIVE;
                else
                    pend_map[tgt] = 1'b1;
            end
            eida_pkg::OP_FLUSH: begin
                for (int k = 0; k < N_IDS; k++) begin
                    if (pend_map[k]) begin
                        pend_map[k] = 1'b0;
                        act_map[k]  = 1'b0;
                        release_id(ID_W'(k));
                        r.cnt = r.cnt + 1'b1;
                    end
                end
            end
            default: begin
                for (int k = 0; k < N_IDS; k++) begin
                    pend_map[k] = 1'b0;
                    if (act_map[k]) begin
                        act_map[k] = 1'b0;
                        release_id(ID_W'(k));
                        r.cnt = r.cnt + 1'b1;
                    end
                end
            end
        endcase
        owed_replies.insert(owed_replies.size(), r);
    endfunction

    // random active ID, or any ID when none is active
    function automatic logic [ID_W-1:0] pick_live();
        int start;
        start = $urandom_range(0, N_IDS - 1);
        for (int k = 0; k < N_IDS; k++) begin
            if (act_map[(start + k) % N_IDS])
                return ID_W'((start + k) % N_IDS);
        end
        return ID_W'($urandom);
    endfunction

    task automatic queue_op(eida_pkg::t_op op, logic [ID_W-1:0] tgt);
        t_alloc_req q;
        q.op  = op;
        q.tgt = tgt;
        req_q.insert(req_q.size(), q);
        n_queued++;
    endtask

    // keep the generator at most one beat ahead so live-ID picks stay current
    task automatic wait_turn();
        while (req_q.size() != 0)
            @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= eida_pkg::OP_CREATE;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                apply_op(eida_pkg::t_op'(s_tuser), s_tdata[ID_W-1:0]);
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(req_q[0].tgt);
                    s_tuser  <= req_q[0].op;
                    req_q.delete(0);
                    tx_gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor
    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_beats++;
                if (owed_replies.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected reply beat: id %0d status %0d count %0d",
                                 m_tdata[ID_W-1:0], m_tuser, m_tdata[ID_W +: CNT_W]);
                end else begin
                    want = owed_replies[0];
                    owed_replies.delete(0);
                    if (m_tdata[ID_W-1:0] !== want.id || m_tuser !== want.st ||
                        m_tdata[ID_W +: CNT_W] !== want.cnt) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("reply %0d: want id %0d st %0d cnt %0d, got %0d %0d %0d",
                                     n_beats, want.id, want.st, want.cnt,
                                     m_tdata[ID_W-1:0], m_tuser, m_tdata[ID_W +: CNT_W]);
                    end
                    case (want.st)
                        eida_pkg::STAT_INACTIVE: n_refused++;
                        eida_pkg::STAT_EMPTY:    n_dry++;
                        default:                 n_grants++;
                    endcase
                    if (int'(want.cnt) > max_batch)
                        max_batch = int'(want.cnt);
                end
                rx_gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int  len;
        int  r;
        bit  drained;
        bit  exhausted;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty ops, kill of inactive, double kill, flush, reuse,
        // clear-all dropping pending kills
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        queue_op(eida_pkg::OP_KILL,   10'd0);
        queue_op(eida_pkg::OP_KILL,   10'h3FF);
        queue_op(eida_pkg::OP_FLUSH,  10'h3FF);
        queue_op(eida_pkg::OP_CLEAR,  10'h2AA);
        queue_op(eida_pkg::OP_CREATE, 10'h155);
        queue_op(eida_pkg::OP_CREATE, 10'h3FF);
        queue_op(eida_pkg::OP_CREATE, 10'd0);
        queue_op(eida_pkg::OP_KILL,   10'd1);
        queue_op(eida_pkg::OP_KILL,   10'd1);
        queue_op(eida_pkg::OP_KILL,   10'd0);
        queue_op(eida_pkg::OP_FLUSH,  10'd0);
        queue_op(eida_pkg::OP_KILL,   10'd1);
        queue_op(eida_pkg::OP_CREATE, 10'd0);
        queue_op(eida_pkg::OP_CREATE, 10'd0);
        queue_op(eida_pkg::OP_CREATE, 10'd0);
        queue_op(eida_pkg::OP_KILL,   10'd2);
        queue_op(eida_pkg::OP_CLEAR,  10'h155);
        queue_op(eida_pkg::OP_FLUSH,  10'h2AA);
        queue_op(eida_pkg::OP_CREATE, 10'd0);
        queue_op(eida_pkg::OP_KILL,   10'd0);
        queue_op(eida_pkg::OP_KILL,   10'h2AA);
        queue_op(eida_pkg::OP_KILL,   10'h155);
        queue_op(eida_pkg::OP_FLUSH,  10'd0);
        queue_op(eida_pkg::OP_CLEAR,  10'd0);

        exhausted = 1'b0;
        while (n_queued < N_REQS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (!exhausted && n_queued >= 400) begin
                // run the ID space dry, refill a little, then release everything
                exhausted = 1'b1;
                wait_turn();
                queue_op(eida_pkg::OP_CLEAR, ID_W'($urandom));
                for (int k = 0; k < N_IDS + 6; k++) begin
                    wait_turn();
                    queue_op(eida_pkg::OP_CREATE, ID_W'($urandom));
                end
                for (int k = 0; k < 5; k++) begin
                    wait_turn();
                    queue_op(eida_pkg::OP_KILL, pick_live());
                end
                queue_op(eida_pkg::OP_FLUSH, ID_W'($urandom));
                for (int k = 0; k < 8; k++) begin
                    wait_turn();
                    queue_op(eida_pkg::OP_CREATE, ID_W'($urandom));
                end
                queue_op(eida_pkg::OP_CLEAR, ID_W'($urandom));
                queue_op(eida_pkg::OP_FLUSH, ID_W'($urandom));
            end else begin
                len = $urandom_range(20, 60);
                for (int j = 0; j < len && n_queued < N_REQS; j++) begin
                    wait_turn();
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        queue_op(eida_pkg::OP_CREATE, ID_W'($urandom));
                    else if (r < 80)
                        queue_op(eida_pkg::OP_KILL,
                                 ($urandom_range(0, 4) != 0) ? pick_live()
                                                             : ID_W'($urandom));
                    else if (r < 95)
                        queue_op(eida_pkg::OP_FLUSH, ID_W'($urandom));
                    else
                        queue_op(eida_pkg::OP_CLEAR, ID_W'($urandom));
                end
            end
        end

        drained = 1'b0;
        while (!drained) begin
            @(negedge i_clk);
            drained = (req_q.size() == 0) && !s_tvalid && (owed_replies.size() == 0);
        end
        repeat (DRAIN_CY) @(negedge i_clk);

        $display("%0d requests, %0d replies: %0d ok, %0d kills refused, %0d creates dry",
                 n_queued, n_beats, n_grants, n_refused, n_dry);
        $display("largest release batch %0d IDs, %0d mismatches", max_batch, n_err);
        if (n_err == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d replies still owed", owed_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/eida_pkg.sv
rtl/eida_ram.sv
rtl/entity_id_allocator_deferred_free.sv
rtl/eida_chk.sv
test/tb_entity_id_allocator_deferred_free.sv
